// ----- rtl/iocrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iocrb_pkg
// Shared widths, register indexes, sequencer codes and the scan unit's flag
// group for the in-order commit reorder buffer.
// ----------------------------------------------------------------------------
package iocrb_pkg;

  // Field widths
  localparam int unsigned NumW       = 32;
  localparam int unsigned HandleW    = 16;
  localparam int unsigned WindowW    = 16;
  localparam int unsigned LimitW     = 4;
  localparam int unsigned DataW      = 48;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  // Most commits released by one event
  localparam int unsigned MaxResults = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SKIP_WINDOW   = 1'b0,
    CFG_PENDING_LIMIT = 1'b1
  } cfg_idx_e;

  // Purpose of a scan over the pending store
  typedef enum logic [1:0] {
    PASS_STORE,
    PASS_COMMIT,
    PASS_TRIM
  } pass_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_STORE_WR,
    ST_PREP,
    ST_COMMIT_DEC,
    ST_FLUSH,
    ST_TRIM_CHK,
    ST_TRIM_DEC
  } state_e;

  // Status of one finished scan
  typedef struct packed {
    logic hit;       // an entry equals the key
    logic best_any;  // a smallest candidate was found
    logic free_any;  // an empty slot was seen
  } scan_flags_t;

endpackage
`default_nettype wire

// ----- rtl/in_order_commit_reorder_buffer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// in_order_commit_reorder_buffer_unit
// Reorder buffer that releases completed frames in frame-number order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries events: tuser is the kind (0 dispatch notice, 1 completed
//   frame), tdata the frame number and handle. m_axis carries commits, tlast
//   marks the final commit caused by an event. cfg_* writes skip_window and
//   pending_limit; write them only while the block is idle.
//   One item is taken at a time; s_axis_tready is high only between events.
//   Each pass over the pending store reads one entry per cycle through the
//   single store read port into one shared compare unit. An event runs one
//   store pass (completions only), one commit pass per commit or skip plus
//   one, and one trim pass per eviction. A commit is held one pass back so
//   that tlast is known; the final one leaves right after the last pass.
//   A stalled receiver holds the output register; the block waits only when a
//   further commit must move out. The last commit may wait there while the
//   next item is accepted.
//   Reset empties the store, clears the pointer and restores the registers
//   (skip_window 8, pending_limit 15).
// ----------------------------------------------------------------------------
module in_order_commit_reorder_buffer_unit #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [iocrb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [iocrb_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // event input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [iocrb_pkg::DataW-1:0]       s_axis_tdata,  // frame_number, frame_handle
  input  logic                              s_axis_tuser,  // mode
  // commit output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [iocrb_pkg::DataW-1:0]       m_axis_tdata,  // commit_number, commit_handle
  output logic                              m_axis_tlast   // last_commit
);
  import iocrb_pkg::*;

  localparam int unsigned IdxW  = $clog2(PENDING_DEPTH);
  localparam int unsigned CntW  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned LimW  = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned NResW = $clog2(MaxResults);

  typedef struct packed {
    logic [NumW-1:0]    num;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Sequencer and event state
  state_e               state_q, state_d;
  pass_e                pass_q, pass_d;
  logic [IdxW-1:0]      scan_idx_q, scan_idx_d;
  logic [NumW-1:0]      ptr_q, ptr_d;
  logic                 pset_q, pset_d;
  logic [NumW-1:0]      high_q, high_d;
  logic                 hset_q, hset_d;
  logic [NumW-1:0]      target_q, target_d;
  logic                 skip_ok_q, skip_ok_d;
  logic                 first_q, first_d;
  logic [NResW-1:0]     n_q, n_d;
  logic [PENDING_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]      count_q, count_d;

  // Latched input item
  logic [NumW-1:0]      num_q;
  logic [HandleW-1:0]   handle_q;

  // Configuration
  logic [WindowW-1:0]   skip_window_q;
  logic [LimitW-1:0]    pending_limit_q;

  // Held commit and output register
  logic                 pend_valid_q, pend_valid_d;
  logic [NumW-1:0]      pend_num_q, pend_num_d;
  logic [HandleW-1:0]   pend_handle_q, pend_handle_d;
  logic                 out_valid_q, out_valid_d;
  logic [NumW-1:0]      out_num_q, out_num_d;
  logic [HandleW-1:0]   out_handle_q, out_handle_d;
  logic                 out_last_q, out_last_d;

  // Store read pipeline
  entry_t               entry_mem [PENDING_DEPTH];
  entry_t               mem_rd_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  entry_t               mem_wdata;
  logic                 beat_act_q;
  logic                 beat_vld_q;
  logic [IdxW-1:0]      beat_idx_q;

  // Scan unit interface
  logic                 scan_clr;
  logic [NumW-1:0]      scan_key;
  logic                 below;
  scan_flags_t          flags;
  logic [IdxW-1:0]      hit_idx;
  logic [HandleW-1:0]   hit_handle;
  logic [NumW-1:0]      best_num;
  logic [IdxW-1:0]      best_idx;
  logic [IdxW-1:0]      free_idx;

  // Misc decision signals
  logic                 accept;
  logic                 out_free;
  logic [IdxW-1:0]      store_slot;
  logic [NumW:0]        gap_diff;
  logic [NumW-1:0]      skip_dest;
  logic [LimW-1:0]      lim_eff;
  logic [LimW-1:0]      limit_ext;
  logic [LimW-1:0]      count_ext;
  logic                 over_limit;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign scan_key = (pass_q == PASS_STORE) ? num_q : ptr_q;

  // Effective limit: never above the store depth minus one
  assign limit_ext  = LimW'(pending_limit_q);
  assign lim_eff    = (limit_ext > LimW'(PENDING_DEPTH - 1)) ? LimW'(PENDING_DEPTH - 1)
                                                              : limit_ext;
  assign count_ext  = LimW'(count_q);
  assign over_limit = (count_ext > lim_eff);

  assign store_slot = flags.hit ? hit_idx : free_idx;
  assign gap_diff   = {1'b0, high_q} - {{(NumW + 1 - WindowW){1'b0}}, skip_window_q};
  assign skip_dest  = (flags.best_any && (best_num < target_q)) ? best_num : target_q;

  // Shared compare unit
  iocrb_scan #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clr_i         (scan_clr),
    .gt_only_i     (pass_q == PASS_COMMIT),
    .key_i         (scan_key),
    .beat_act_i    (beat_act_q),
    .beat_vld_i    (beat_vld_q),
    .beat_idx_i    (beat_idx_q),
    .beat_num_i    (mem_rd_q.num),
    .beat_handle_i (mem_rd_q.handle),
    .below_o       (below),
    .flags_o       (flags),
    .hit_idx_o     (hit_idx),
    .hit_handle_o  (hit_handle),
    .best_num_o    (best_num),
    .best_idx_o    (best_idx),
    .free_idx_o    (free_idx)
  );

  // Next state and datapath control
  always_comb begin
    state_d       = state_q;
    pass_d        = pass_q;
    scan_idx_d    = scan_idx_q;
    ptr_d         = ptr_q;
    pset_d        = pset_q;
    high_d        = high_q;
    hset_d        = hset_q;
    target_d      = target_q;
    skip_ok_d     = skip_ok_q;
    first_d       = first_q;
    n_d           = n_q;
    valid_d       = valid_q;
    count_d       = count_q;
    pend_valid_d  = pend_valid_q;
    pend_num_d    = pend_num_q;
    pend_handle_d = pend_handle_q;
    out_valid_d   = out_valid_q;
    out_num_d     = out_num_q;
    out_handle_d  = out_handle_q;
    out_last_d    = out_last_q;
    mem_we        = 1'b0;
    mem_waddr     = store_slot;
    mem_wdata     = '{num: num_q, handle: handle_q};
    scan_clr      = 1'b0;

    // Drain the output register
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // Drop stale entries during the first commit pass
    if ((pass_q == PASS_COMMIT) && first_q && below) begin
      valid_d[beat_idx_q] = 1'b0;
      count_d             = count_q - CntW'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser) begin
            if (!pset_q) begin
              ptr_d  = s_axis_tdata[NumW-1:0];
              pset_d = 1'b1;
            end
            if (!hset_q || (s_axis_tdata[NumW-1:0] > high_q)) begin
              high_d = s_axis_tdata[NumW-1:0];
              hset_d = 1'b1;
            end
            state_d = ST_PREP;
          end else begin
            pass_d  = PASS_STORE;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        scan_clr   = (scan_idx_q == '0);
        scan_idx_d = scan_idx_q + IdxW'(1);
        if (scan_idx_q == IdxW'(PENDING_DEPTH - 1)) begin
          scan_idx_d = '0;
          state_d    = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        unique case (pass_q)
          PASS_STORE:  state_d = ST_STORE_WR;
          PASS_COMMIT: state_d = ST_COMMIT_DEC;
          PASS_TRIM:   state_d = ST_TRIM_DEC;
          default:     state_d = ST_IDLE;
        endcase
      end

      // Overwrite a matching entry or fill a free slot
      ST_STORE_WR: begin
        mem_we               = 1'b1;
        valid_d[store_slot]  = 1'b1;
        if (!flags.hit) begin
          count_d = count_q + CntW'(1);
        end
        if (!pset_q) begin
          ptr_d  = (flags.best_any && (best_num < num_q)) ? best_num : num_q;
          pset_d = 1'b1;
        end
        state_d = ST_PREP;
      end

      // Work out the skip threshold for this event
      ST_PREP: begin
        skip_ok_d = hset_q && !gap_diff[NumW];
        target_d  = gap_diff[NumW-1:0];
        if (pset_q) begin
          pass_d  = PASS_COMMIT;
          first_d = 1'b1;
          n_d     = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_TRIM_CHK;
        end
      end

      // Commit the entry at the pointer, else skip, else finish
      ST_COMMIT_DEC: begin
        first_d = 1'b0;
        if (flags.hit) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_num_d    = pend_num_q;
              out_handle_d = pend_handle_q;
              out_last_d   = 1'b0;
            end
            pend_valid_d     = 1'b1;
            pend_num_d       = ptr_q;
            pend_handle_d    = hit_handle;
            valid_d[hit_idx] = 1'b0;
            count_d          = count_q - CntW'(1);
            ptr_d            = ptr_q + NumW'(1);
            n_d              = n_q + NResW'(1);
            state_d          = (n_q == NResW'(MaxResults - 1)) ? ST_FLUSH : ST_SCAN;
          end
        end else if (skip_ok_q && (ptr_q < target_q)) begin
          ptr_d   = skip_dest;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FLUSH;
        end
      end

      // Release the held commit as the last of this event
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_TRIM_CHK;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_num_d    = pend_num_q;
          out_handle_d = pend_handle_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_TRIM_CHK;
        end
      end

      ST_TRIM_CHK: begin
        if (over_limit) begin
          pass_d  = PASS_TRIM;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Evict the smallest entry
      ST_TRIM_DEC: begin
        if (flags.best_any) begin
          valid_d[best_idx] = 1'b0;
          count_d           = count_q - CntW'(1);
          state_d           = ST_TRIM_CHK;
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_q       <= PASS_STORE;
      scan_idx_q   <= '0;
      ptr_q        <= '0;
      pset_q       <= 1'b0;
      high_q       <= '0;
      hset_q       <= 1'b0;
      skip_ok_q    <= 1'b0;
      first_q      <= 1'b0;
      n_q          <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      beat_act_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_q       <= pass_d;
      scan_idx_q   <= scan_idx_d;
      ptr_q        <= ptr_d;
      pset_q       <= pset_d;
      high_q       <= high_d;
      hset_q       <= hset_d;
      skip_ok_q    <= skip_ok_d;
      first_q      <= first_d;
      n_q          <= n_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      beat_act_q   <= (state_q == ST_SCAN);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_window_q   <= WindowW'(8);
      pending_limit_q <= LimitW'(15);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SKIP_WINDOW:   skip_window_q   <= cfg_wdata_i[WindowW-1:0];
        CFG_PENDING_LIMIT: pending_limit_q <= cfg_wdata_i[LimitW-1:0];
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q    <= s_axis_tdata[NumW-1:0];
      handle_q <= s_axis_tdata[NumW+HandleW-1:NumW];
    end
    target_q      <= target_d;
    pend_num_q    <= pend_num_d;
    pend_handle_q <= pend_handle_d;
    out_num_q     <= out_num_d;
    out_handle_q  <= out_handle_d;
    out_last_q    <= out_last_d;
    beat_vld_q    <= valid_q[scan_idx_q];
    beat_idx_q    <= scan_idx_q;
  end

  // Pending store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= entry_mem[scan_idx_q];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_handle_q, out_num_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // Fill count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("fill count does not match valid bits");

  // No commit is left held between events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held commit left behind at idle");

  // Store keeps a free slot for the next completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (count_q <= CntW'(PENDING_DEPTH - 1)))
    else $error("pending store over capacity at idle");

  // A new number always finds a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STORE_WR) && !flags.hit) |-> flags.free_any)
    else $error("no free slot for a new entry");

  // A committed entry is still live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMMIT_DEC) && flags.hit) |-> valid_q[hit_idx])
    else $error("commit of an entry that is not valid");
`endif

endmodule
`default_nettype wire

// ----- rtl/iocrb_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iocrb_scan
// Shared compare unit: takes one store entry per cycle and keeps the entry
// matching the key, the smallest candidate entry and the first empty slot.
// ----------------------------------------------------------------------------
module iocrb_scan #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic                                gt_only_i,
  input  logic [iocrb_pkg::NumW-1:0]          key_i,
  input  logic                                beat_act_i,
  input  logic                                beat_vld_i,
  input  logic [$clog2(PENDING_DEPTH)-1:0]    beat_idx_i,
  input  logic [iocrb_pkg::NumW-1:0]          beat_num_i,
  input  logic [iocrb_pkg::HandleW-1:0]       beat_handle_i,
  output logic                                below_o,
  output iocrb_pkg::scan_flags_t              flags_o,
  output logic [$clog2(PENDING_DEPTH)-1:0]    hit_idx_o,
  output logic [iocrb_pkg::HandleW-1:0]       hit_handle_o,
  output logic [iocrb_pkg::NumW-1:0]          best_num_o,
  output logic [$clog2(PENDING_DEPTH)-1:0]    best_idx_o,
  output logic [$clog2(PENDING_DEPTH)-1:0]    free_idx_o
);
  import iocrb_pkg::*;

  localparam int unsigned IdxW = $clog2(PENDING_DEPTH);

  scan_flags_t          flags_q, flags_d;
  logic [IdxW-1:0]      hit_idx_q;
  logic [HandleW-1:0]   hit_handle_q;
  logic [NumW-1:0]      best_num_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [IdxW-1:0]      free_idx_q;

  logic eq_key, lt_key, lt_best, eligible;
  logic take_hit, take_best, take_free;

  // Compare the current entry against the key and the best so far
  assign eq_key   = (beat_num_i == key_i);
  assign lt_key   = (beat_num_i < key_i);
  assign lt_best  = (beat_num_i < best_num_q);
  assign eligible = beat_vld_i && (!gt_only_i || (!eq_key && !lt_key));

  assign take_hit  = beat_act_i && beat_vld_i && eq_key && !flags_q.hit;
  assign take_best = beat_act_i && eligible && (!flags_q.best_any || lt_best);
  assign take_free = beat_act_i && !beat_vld_i && !flags_q.free_any;

  assign below_o = beat_act_i && beat_vld_i && lt_key;

  // Accumulate flags; clear at the start of each pass
  always_comb begin
    flags_d = flags_q;
    if (clr_i) begin
      flags_d = '0;
    end else begin
      if (take_hit)  flags_d.hit      = 1'b1;
      if (take_best) flags_d.best_any = 1'b1;
      if (take_free) flags_d.free_any = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Capture the data that goes with each flag
  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q    <= beat_idx_i;
      hit_handle_q <= beat_handle_i;
    end
    if (take_best) begin
      best_num_q <= beat_num_i;
      best_idx_q <= beat_idx_i;
    end
    if (take_free) begin
      free_idx_q <= beat_idx_i;
    end
  end

  assign flags_o      = flags_q;
  assign hit_idx_o    = hit_idx_q;
  assign hit_handle_o = hit_handle_q;
  assign best_num_o   = best_num_q;
  assign best_idx_o   = best_idx_q;
  assign free_idx_o   = free_idx_q;

endmodule
`default_nettype wire
